// ===== rtl/core/kq4_pkg.sv =====
// shared widths and default parameters of the 4-bit k-quant dot product
package kq4_pkg;

  // fixed field widths
  localparam int BYTE_W  = 8;
  localparam int NIB_W   = 4;
  localparam int CODE_W  = 7;
  localparam int FLAG_W  = 1;
  localparam int OUT_W   = 64;

  // parameter defaults
  localparam int ACT_WIDTH_DEF    = 16;
  localparam int FACTOR_WIDTH_DEF = 24;
  localparam int ACC_WIDTH_DEF    = 64;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // extra bits: code*step+base grows by the code width plus one carry
  localparam int SCALE_GROW  = CODE_W + 1;
  // nibble*scale+min grows by a signed nibble plus one carry
  localparam int WEIGHT_GROW = NIB_W + 2;

endpackage

// ===== rtl/core/k_quant_four_bit_dot_product.sv =====
// top level of the 4-bit k-quant fused dot product
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------------
//   item     | item_valid / item_stall    | weight byte, two activations, codes, factors
//   result   | result_valid / result_stall| dot_sum, overflowed
//
// one byte per cycle unless item_stall; the accumulator add is a single-register loop
// a result passes from its last byte through the front register, the queue, the
// weight, product and clamp stages and the result register
// rst is synchronous and clears all valid flags, the queue and the accumulator
// a stalled result holds the back pipeline once a further last byte reaches the
// accumulator; the four-entry queue lets the front keep taking bytes until it fills
module k_quant_four_bit_dot_product #(
  parameter int ACT_WIDTH    = kq4_pkg::ACT_WIDTH_DEF,
  parameter int FACTOR_WIDTH = kq4_pkg::FACTOR_WIDTH_DEF,
  parameter int ACC_WIDTH    = kq4_pkg::ACC_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [kq4_pkg::BYTE_W-1:0]      weight_byte,
  input  logic signed [ACT_WIDTH-1:0]     act_first,
  input  logic signed [ACT_WIDTH-1:0]     act_second,
  input  logic [kq4_pkg::CODE_W-1:0]      sub_scale_code,
  input  logic [kq4_pkg::CODE_W-1:0]      sub_min_code,
  input  logic signed [FACTOR_WIDTH-1:0]  super_scale_step,
  input  logic signed [FACTOR_WIDTH-1:0]  super_scale_base,
  input  logic signed [FACTOR_WIDTH-1:0]  super_min_step,
  input  logic signed [FACTOR_WIDTH-1:0]  super_min_base,
  input  logic                            last_of_dot,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [kq4_pkg::OUT_W-1:0]       dot_sum,
  output logic                            overflowed
);

  localparam int SCALE_W = FACTOR_WIDTH + kq4_pkg::SCALE_GROW;
  localparam int DATA_W  = kq4_pkg::BYTE_W + 2 * ACT_WIDTH + 2 * SCALE_W
                           + kq4_pkg::FLAG_W;

  logic                        f_valid;
  logic                        f_stall;
  logic [kq4_pkg::BYTE_W-1:0]  f_byte;
  logic signed [ACT_WIDTH-1:0] f_act0;
  logic signed [ACT_WIDTH-1:0] f_act1;
  logic signed [SCALE_W-1:0]   f_scale;
  logic signed [SCALE_W-1:0]   f_min;
  logic                        f_last;

  logic [DATA_W-1:0]           push_data;
  logic [DATA_W-1:0]           pop_data;
  logic                        q_valid;
  logic                        q_stall;
  logic [kq4_pkg::BYTE_W-1:0]  q_byte;
  logic signed [ACT_WIDTH-1:0] q_act0;
  logic signed [ACT_WIDTH-1:0] q_act1;
  logic signed [SCALE_W-1:0]   q_scale;
  logic signed [SCALE_W-1:0]   q_min;
  logic                        q_last;

  // front: take byte, form scale and min
  kq4_front #(
    .ACT_WIDTH    (ACT_WIDTH),
    .FACTOR_WIDTH (FACTOR_WIDTH),
    .SCALE_W      (SCALE_W)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .weight_byte      (weight_byte),
    .act_first        (act_first),
    .act_second       (act_second),
    .sub_scale_code   (sub_scale_code),
    .sub_min_code     (sub_min_code),
    .super_scale_step (super_scale_step),
    .super_scale_base (super_scale_base),
    .super_min_step   (super_min_step),
    .super_min_base   (super_min_base),
    .last_of_dot      (last_of_dot),
    .f_valid          (f_valid),
    .f_stall          (f_stall),
    .f_byte           (f_byte),
    .f_act0           (f_act0),
    .f_act1           (f_act1),
    .f_scale          (f_scale),
    .f_min            (f_min),
    .f_last           (f_last)
  );

  // pack and unpack the queue entry
  assign push_data = {f_byte, f_act0, f_act1, f_scale, f_min, f_last};
  assign {q_byte, q_act0, q_act1, q_scale, q_min, q_last} = pop_data;

  kq4_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (kq4_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_data   (pop_data)
  );

  // back: dequantize, multiply, accumulate, present result
  kq4_back #(
    .ACT_WIDTH    (ACT_WIDTH),
    .FACTOR_WIDTH (FACTOR_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH),
    .SCALE_W      (SCALE_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_stall      (q_stall),
    .q_byte       (q_byte),
    .q_act0       (q_act0),
    .q_act1       (q_act1),
    .q_scale      (q_scale),
    .q_min        (q_min),
    .q_last       (q_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .dot_sum      (dot_sum),
    .overflowed   (overflowed)
  );

endmodule

// ===== rtl/core/kq4_front.sv =====
// front stage: accepts a byte and forms the sub-block scale and min
module kq4_front #(
  parameter int ACT_WIDTH    = kq4_pkg::ACT_WIDTH_DEF,
  parameter int FACTOR_WIDTH = kq4_pkg::FACTOR_WIDTH_DEF,
  parameter int SCALE_W      = FACTOR_WIDTH + kq4_pkg::SCALE_GROW
) (
  input  logic                            clk,
  input  logic                            rst,
  // item side
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [kq4_pkg::BYTE_W-1:0]      weight_byte,
  input  logic signed [ACT_WIDTH-1:0]     act_first,
  input  logic signed [ACT_WIDTH-1:0]     act_second,
  input  logic [kq4_pkg::CODE_W-1:0]      sub_scale_code,
  input  logic [kq4_pkg::CODE_W-1:0]      sub_min_code,
  input  logic signed [FACTOR_WIDTH-1:0]  super_scale_step,
  input  logic signed [FACTOR_WIDTH-1:0]  super_scale_base,
  input  logic signed [FACTOR_WIDTH-1:0]  super_min_step,
  input  logic signed [FACTOR_WIDTH-1:0]  super_min_base,
  input  logic                            last_of_dot,
  // queue side
  output logic                            f_valid,
  input  logic                            f_stall,
  output logic [kq4_pkg::BYTE_W-1:0]      f_byte,
  output logic signed [ACT_WIDTH-1:0]     f_act0,
  output logic signed [ACT_WIDTH-1:0]     f_act1,
  output logic signed [SCALE_W-1:0]       f_scale,
  output logic signed [SCALE_W-1:0]       f_min,
  output logic                            f_last
);

  logic                      f_ready;
  logic                      take;
  logic signed [SCALE_W-1:0] scale_next;
  logic signed [SCALE_W-1:0] min_next;

  // stage is free when empty or its content moves on this cycle
  assign f_ready    = !f_valid || !f_stall;
  assign item_stall = !f_ready;
  assign take       = item_valid && f_ready;

  // code times step plus base, exact
  assign scale_next =
    SCALE_W'($signed({1'b0, sub_scale_code})) * SCALE_W'(super_scale_step)
    + SCALE_W'(super_scale_base);
  assign min_next =
    SCALE_W'($signed({1'b0, sub_min_code})) * SCALE_W'(super_min_step)
    + SCALE_W'(super_min_base);

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_ready) begin
      f_valid <= item_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      f_byte  <= weight_byte;
      f_act0  <= act_first;
      f_act1  <= act_second;
      f_scale <= scale_next;
      f_min   <= min_next;
      f_last  <= last_of_dot;
    end
  end

endmodule

// ===== rtl/core/kq4_queue.sv =====
// short fifo between the front stage and the back pipeline
module kq4_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = kq4_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_stall,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_stall,
  output logic [DATA_W-1:0] pop_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0]  wr_ptr;
  logic [IDX_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push_ok;
  logic              pop_ok;

  assign push_stall = (count == CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push_ok    = push_valid && !push_stall;
  assign pop_ok     = pop_valid && !pop_stall;
  assign pop_data   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  // fill count stays within depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  // a lone push grows the count by one
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push_ok && !pop_ok) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on push");

  // a lone pop shrinks the count by one
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (pop_ok && !push_ok) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not shrink on pop");

endmodule

// ===== rtl/core/kq4_back.sv =====
// back pipeline: dequantize, multiply, clamp and accumulate
module kq4_back #(
  parameter int ACT_WIDTH    = kq4_pkg::ACT_WIDTH_DEF,
  parameter int FACTOR_WIDTH = kq4_pkg::FACTOR_WIDTH_DEF,
  parameter int ACC_WIDTH    = kq4_pkg::ACC_WIDTH_DEF,
  parameter int SCALE_W      = FACTOR_WIDTH + kq4_pkg::SCALE_GROW
) (
  input  logic                        clk,
  input  logic                        rst,
  // queue side
  input  logic                        q_valid,
  output logic                        q_stall,
  input  logic [kq4_pkg::BYTE_W-1:0]  q_byte,
  input  logic signed [ACT_WIDTH-1:0] q_act0,
  input  logic signed [ACT_WIDTH-1:0] q_act1,
  input  logic signed [SCALE_W-1:0]   q_scale,
  input  logic signed [SCALE_W-1:0]   q_min,
  input  logic                        q_last,
  // result side
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [kq4_pkg::OUT_W-1:0]   dot_sum,
  output logic                        overflowed
);

  localparam int WT_W   = SCALE_W + kq4_pkg::WEIGHT_GROW;
  localparam int PROD_W = WT_W + ACT_WIDTH;
  localparam int EXT_W  = PROD_W + ACC_WIDTH;
  localparam int TOP_W  = EXT_W - ACC_WIDTH + 1;
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH - 1){1'b0}}};

  // clamp a product into the accumulator range, flag in the top bit
  function automatic logic [ACC_WIDTH:0] clamp_prod(input logic signed [PROD_W-1:0] p);
    logic signed [EXT_W-1:0] x;
    logic [TOP_W-1:0]        top;
    logic                    fits;
    x    = EXT_W'(p);
    top  = x[EXT_W-1:ACC_WIDTH-1];
    fits = (top == '0) || (top == '1);
    if (fits) begin
      clamp_prod = {1'b0, x[ACC_WIDTH-1:0]};
    end else if (x[EXT_W-1]) begin
      clamp_prod = {1'b1, ACC_MIN};
    end else begin
      clamp_prod = {1'b1, ACC_MAX};
    end
  endfunction

  // saturating add, flag in the top bit
  function automatic logic [ACC_WIDTH:0] sat_add(input logic signed [ACC_WIDTH-1:0] a,
                                                  input logic signed [ACC_WIDTH-1:0] b);
    logic signed [ACC_WIDTH:0] s;
    s = (ACC_WIDTH + 1)'(a) + (ACC_WIDTH + 1)'(b);
    if (s[ACC_WIDTH] == s[ACC_WIDTH-1]) begin
      sat_add = {1'b0, s[ACC_WIDTH-1:0]};
    end else if (s[ACC_WIDTH]) begin
      sat_add = {1'b1, ACC_MIN};
    end else begin
      sat_add = {1'b1, ACC_MAX};
    end
  endfunction

  // weight stage
  logic                      w_valid;
  logic                      w_ready;
  logic signed [WT_W-1:0]    w0;
  logic signed [WT_W-1:0]    w1;
  logic signed [ACT_WIDTH-1:0] w_act0;
  logic signed [ACT_WIDTH-1:0] w_act1;
  logic                      w_last;
  logic signed [WT_W-1:0]    nib_hi;
  logic signed [WT_W-1:0]    nib_lo;
  logic signed [WT_W-1:0]    scale_x;
  logic signed [WT_W-1:0]    min_x;

  // product stage
  logic                      p_valid;
  logic                      p_ready;
  logic signed [PROD_W-1:0]  p0;
  logic signed [PROD_W-1:0]  p1;
  logic                      p_last;

  // clamp stage
  logic                      c_valid;
  logic                      c_ready;
  logic signed [ACC_WIDTH-1:0] c0;
  logic signed [ACC_WIDTH-1:0] c1;
  logic                      c_sat;
  logic                      c_last;
  logic [ACC_WIDTH:0]        cl0;
  logic [ACC_WIDTH:0]        cl1;

  // accumulator
  logic signed [ACC_WIDTH-1:0] running_sum;
  logic                        saturated_seen;
  logic [ACC_WIDTH:0]          add0;
  logic [ACC_WIDTH:0]          add1;
  logic signed [ACC_WIDTH-1:0] sum_next;
  logic                        seen_next;
  logic                        out_free;
  logic                        acc_take;
  logic signed [ACC_WIDTH-1:0] result_sum;

  // handshake between stages
  assign out_free = !result_valid || !result_stall;
  assign acc_take = c_valid && (!c_last || out_free);
  assign c_ready  = !c_valid || acc_take;
  assign p_ready  = !p_valid || c_ready;
  assign w_ready  = !w_valid || p_ready;
  assign q_stall  = !w_ready;

  // nibble times scale plus min
  assign nib_hi  = WT_W'($signed({1'b0, q_byte[kq4_pkg::BYTE_W-1:kq4_pkg::NIB_W]}));
  assign nib_lo  = WT_W'($signed({1'b0, q_byte[kq4_pkg::NIB_W-1:0]}));
  assign scale_x = WT_W'(q_scale);
  assign min_x   = WT_W'(q_min);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else if (w_ready) begin
      w_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (w_ready && q_valid) begin
      w0     <= nib_hi * scale_x + min_x;
      w1     <= nib_lo * scale_x + min_x;
      w_act0 <= q_act0;
      w_act1 <= q_act1;
      w_last <= q_last;
    end
  end

  // weight times activation
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= w_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && w_valid) begin
      p0     <= PROD_W'(w0) * PROD_W'(w_act0);
      p1     <= PROD_W'(w1) * PROD_W'(w_act1);
      p_last <= w_last;
    end
  end

  // clamp products to accumulator range
  assign cl0 = clamp_prod(p0);
  assign cl1 = clamp_prod(p1);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && p_valid) begin
      c0     <= cl0[ACC_WIDTH-1:0];
      c1     <= cl1[ACC_WIDTH-1:0];
      c_sat  <= cl0[ACC_WIDTH] | cl1[ACC_WIDTH];
      c_last <= p_last;
    end
  end

  // first product, then second, each add saturating
  assign add0      = sat_add(running_sum, c0);
  assign add1      = sat_add(add0[ACC_WIDTH-1:0], c1);
  assign sum_next  = add1[ACC_WIDTH-1:0];
  assign seen_next = saturated_seen | c_sat | add0[ACC_WIDTH] | add1[ACC_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      saturated_seen <= 1'b0;
    end else if (acc_take) begin
      if (c_last) begin
        running_sum    <= '0;
        saturated_seen <= 1'b0;
      end else begin
        running_sum    <= sum_next;
        saturated_seen <= seen_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (acc_take && c_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_take && c_last) begin
      result_sum <= sum_next;
      overflowed <= seen_next;
    end
  end

  assign dot_sum = kq4_pkg::OUT_W'(result_sum);

  // closing a dot product leaves a clean accumulator
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (acc_take && c_last) |=> (running_sum == '0 && !saturated_seen))
    else $error("accumulator not cleared after last byte");

  // a clamped product is remembered until the dot product closes
  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    (acc_take && c_sat && !c_last) |=> saturated_seen)
    else $error("product clamp not recorded");

  // a waiting result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !(acc_take && c_last))
    else $error("result register overrun");

endmodule
